// File: hdl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared constants and types of the double-hashing bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

	localparam int unsigned MAX_BITS_DEF   = 65536;
	localparam int unsigned MAX_PROBES_DEF = 32;

	localparam int unsigned BIT_COUNT_W   = 17;
	localparam int unsigned PROBE_COUNT_W = 6;
	localparam int unsigned CFG_DATA_W    = 17;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned KEY_W         = 64;

	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;

	localparam logic [BIT_COUNT_W-1:0]   BIT_COUNT_RST   = 17'd65536;
	localparam logic [PROBE_COUNT_W-1:0] PROBE_COUNT_RST = 6'd7;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [63:0] SEED_A = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] SEED_B = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MUL_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MUL_B  = 64'h94D049BB133111EB;

	typedef enum logic [1:0] {
		RSEL_H1,
		RSEL_H2,
		RSEL_ONES
	} rsel_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED,
		ST_MA_GO,
		ST_MA_WAIT,
		ST_MB_GO,
		ST_MB_WAIT,
		ST_REM_GO,
		ST_REM_WAIT,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_RESULT
	} state_t;

endpackage

// File: hdl/bfdh_mul.sv
// ----------------------------------------------------------------------------
// bfdh_mul
// Low 64 bits of a 64x64 product, built from three passes through one
// registered 32x32 multiplier.
// ----------------------------------------------------------------------------
module bfdh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);
	import bfdh_pkg::*;

	logic [63:0] a_q, b_q, acc_q, pp_q;
	logic [1:0]  cnt_q;
	logic        busy_q, done_q;
	logic [31:0] ma, mb;

	always_comb begin
		case (cnt_q)
			2'd0:    begin ma = a_q[31:0];  mb = b_q[31:0];  end
			2'd1:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
			default: begin ma = a_q[63:32]; mb = b_q[31:0];  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			pp_q <= 64'(ma) * 64'(mb);
			case (cnt_q)
				2'd0:    acc_q <= acc_q;
				2'd1:    acc_q <= pp_q;
				default: acc_q[63:32] <= acc_q[63:32] + pp_q[31:0];
			endcase
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: hdl/bfdh_rem.sv
// ----------------------------------------------------------------------------
// bfdh_rem
// Serial restoring remainder of a 64-bit word by the filter size, one bit
// per cycle.
// ----------------------------------------------------------------------------
module bfdh_rem #(
	parameter int unsigned NBW = 17
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [63:0]    x,
	input  logic [NBW-1:0] n,
	output logic           done,
	output logic [NBW-1:0] rem
);
	import bfdh_pkg::*;

	logic [63:0]    x_q;
	logic [NBW-1:0] rem_q;
	logic [5:0]     cnt_q;
	logic           busy_q, done_q;
	logic [NBW:0]   t, d;

	assign t = {rem_q, x_q[63]};
	assign d = t - {1'b0, n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			rem_q <= '0;
		end else if (busy_q) begin
			x_q   <= {x_q[62:0], 1'b0};
			rem_q <= (t >= {1'b0, n}) ? d[NBW-1:0] : t[NBW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hdl/bfdh_store.sv
// ----------------------------------------------------------------------------
// bfdh_store
// Byte-wide filter bit memory with registered read and a clearing sweep
// after reset.
// ----------------------------------------------------------------------------
module bfdh_store #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata,
	output logic          ready
);
	import bfdh_pkg::*;

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          clr_busy_q;
	logic [7:0]    rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (32'(clr_q) == DEPTH - 1)
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_q] <= 8'd0;
		else if (we)
			mem[addr] <= wdata;
		if (rd_en)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
	assign ready = !clr_busy_q;

endmodule

// File: hdl/bloom_filter_double_hash.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// Flow: each accepted word goes through two mixes on a shared 32x32
// multiplier and three serial remainders, then each probe reads and checks
// its bit; a query answer is registered once the output register is free.
// Throughput: one key at a time; in_ready is low while a key is in work.
// Reset: a clearing sweep over all DEPTH bytes zeroes the bit memory; no key
// is taken until it ends. Configuration resets to 65536 bits and 7 probes.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash #(
	parameter int unsigned MAX_BITS   = bfdh_pkg::MAX_BITS_DEF,
	parameter int unsigned MAX_PROBES = bfdh_pkg::MAX_PROBES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [bfdh_pkg::KEY_W-1:0]     key_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           maybe_present,
	input  logic                           cfg_we,
	input  logic [bfdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bfdh_pkg::*;

	localparam int unsigned NBW   = $clog2(MAX_BITS + 1);
	localparam int unsigned KW    = $clog2(MAX_PROBES + 1);
	localparam int unsigned DEPTH = (MAX_BITS + 7) / 8;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned BW    = (NBW > AW + 3) ? NBW : AW + 3;

	state_t state_q, state_d;

	logic [BIT_COUNT_W-1:0]   bit_count_q;
	logic [PROBE_COUNT_W-1:0] probe_count_q;
	logic [NBW-1:0] n_w;
	logic [KW-1:0]  k_w;

	logic        op_q, second_q, res_q, out_valid_q, maybe_q;
	logic [63:0] key_q, v_q, h1_q, h2_q, s_q;
	logic [NBW-1:0] r_q, r2_q, w_q;
	logic [KW-1:0]  i_q;
	rsel_t       rsel_q;

	logic        mul_start, mul_done, rem_start, rem_done;
	logic [63:0] mul_a, mul_b, mul_p, rem_x, hmix;
	logic [NBW-1:0] rem_r;
	logic        rd_en, we, st_ready, load_out;
	logic [AW-1:0] addr;
	logic [7:0]  rdata, mask;
	logic [BW-1:0] bext;
	logic        last, bit_set, carry;
	logic [63:0] s_next;
	logic [NBW:0] x1, x1r, y1, m1;
	logic [NBW-1:0] r_next, w_new;

	always_comb begin
		if (bit_count_q < BIT_COUNT_W'(8))
			n_w = NBW'(8);
		else if (32'(bit_count_q) > MAX_BITS)
			n_w = NBW'(MAX_BITS);
		else
			n_w = NBW'(bit_count_q);
		if (probe_count_q == '0)
			k_w = KW'(1);
		else if (32'(probe_count_q) > MAX_PROBES)
			k_w = KW'(MAX_PROBES);
		else
			k_w = KW'(probe_count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q   <= BIT_COUNT_RST;
			probe_count_q <= PROBE_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_BIT_COUNT)
				bit_count_q <= cfg_data[BIT_COUNT_W-1:0];
			else if (cfg_index == REG_PROBE_COUNT)
				probe_count_q <= cfg_data[PROBE_COUNT_W-1:0];
		end
	end

	assign mul_a = (state_q == ST_MA_GO) ? (v_q ^ (v_q >> 30)) : (v_q ^ (v_q >> 27));
	assign mul_b = (state_q == ST_MA_GO) ? MUL_A : MUL_B;
	assign hmix  = mul_p ^ (mul_p >> 31);

	bfdh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	always_comb begin
		case (rsel_q)
			RSEL_H1: rem_x = h1_q;
			RSEL_H2: rem_x = h2_q;
			default: rem_x = '1;
		endcase
	end

	bfdh_rem #(.NBW(NBW)) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.x      (rem_x),
		.n      (n_w),
		.done   (rem_done),
		.rem    (rem_r)
	);

	assign bext = BW'(r_q);
	assign addr = bext[AW+2:3];
	assign mask = 8'd1 << r_q[2:0];

	bfdh_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.we     (we),
		.addr   (addr),
		.wdata  (rdata | mask),
		.rdata  (rdata),
		.ready  (st_ready)
	);

	assign bit_set       = (rdata & mask) != 8'd0;
	assign last          = ((KW+1)'(i_q) + (KW+1)'(1)) == (KW+1)'(k_w);
	assign {carry, s_next} = {1'b0, s_q} + {1'b0, h2_q};

	always_comb begin
		x1  = {1'b0, r_q} + {1'b0, r2_q};
		x1r = (x1 >= {1'b0, n_w}) ? x1 - {1'b0, n_w} : x1;
		y1  = x1r - {1'b0, w_q};
		if (!carry)
			r_next = x1r[NBW-1:0];
		else if (x1r < {1'b0, w_q})
			r_next = NBW'(y1 + {1'b0, n_w});
		else
			r_next = y1[NBW-1:0];
		m1    = {1'b0, rem_r} + (NBW+1)'(1);
		w_new = (m1 == {1'b0, n_w}) ? '0 : m1[NBW-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (st_ready) state_d = ST_IDLE;
			ST_IDLE:     if (in_valid) state_d = ST_SEED;
			ST_SEED:     state_d = ST_MA_GO;
			ST_MA_GO:    state_d = ST_MA_WAIT;
			ST_MA_WAIT:  if (mul_done) state_d = ST_MB_GO;
			ST_MB_GO:    state_d = ST_MB_WAIT;
			ST_MB_WAIT:  if (mul_done) state_d = second_q ? ST_REM_GO : ST_SEED;
			ST_REM_GO:   state_d = ST_REM_WAIT;
			ST_REM_WAIT: if (rem_done) state_d = (rsel_q == RSEL_ONES) ? ST_PROBE_RD : ST_REM_GO;
			ST_PROBE_RD: state_d = ST_PROBE_CHK;
			ST_PROBE_CHK: begin
				if (op_q == OP_QUERY && !bit_set)
					state_d = ST_RESULT;
				else if (last)
					state_d = (op_q == OP_QUERY) ? ST_RESULT : ST_IDLE;
				else
					state_d = ST_PROBE_RD;
			end
			ST_RESULT:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		mul_start = (state_q == ST_MA_GO) || (state_q == ST_MB_GO);
		rem_start = (state_q == ST_REM_GO);
		rd_en     = (state_q == ST_PROBE_RD);
		we        = (state_q == ST_PROBE_CHK) && (op_q == OP_ADD);
		load_out  = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			maybe_q <= res_q;
		case (state_q)
			ST_IDLE: begin
				op_q     <= op;
				key_q    <= key_value;
				second_q <= 1'b0;
				rsel_q   <= RSEL_H1;
				i_q      <= '0;
				res_q    <= 1'b1;
			end
			ST_SEED:    v_q <= (key_q ^ (second_q ? SEED_B : SEED_A)) + GOLDEN;
			ST_MA_WAIT: if (mul_done) v_q <= mul_p;
			ST_MB_WAIT: begin
				if (mul_done) begin
					if (second_q) begin
						h2_q <= hmix;
					end else begin
						h1_q     <= hmix;
						s_q      <= hmix;
						second_q <= 1'b1;
					end
				end
			end
			ST_REM_WAIT: begin
				if (rem_done) begin
					case (rsel_q)
						RSEL_H1: begin r_q  <= rem_r; rsel_q <= RSEL_H2;   end
						RSEL_H2: begin r2_q <= rem_r; rsel_q <= RSEL_ONES; end
						default: w_q <= w_new;
					endcase
				end
			end
			ST_PROBE_CHK: begin
				if (op_q == OP_QUERY && !bit_set) begin
					res_q <= 1'b0;
				end else begin
					i_q <= i_q + KW'(1);
					s_q <= s_next;
					r_q <= r_next;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign maybe_present = maybe_q;

endmodule

// File: tb/sv/tb_bloom_filter_double_hash.sv
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash
// Drives add and query words into the bloom filter under changing bit and
// probe counts, keeps a shadow bit store and checks every query answer.
// ----------------------------------------------------------------------------
module tb_bloom_filter_double_hash;
	timeunit 1ns;
	timeprecision 1ps;

	import bfdh_pkg::*;

	localparam int unsigned STORE_BITS = MAX_BITS_DEF;
	localparam int unsigned SETTLE_CYC = 600;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    op;
	logic [KEY_W-1:0]        key_value;
	logic                    out_valid;
	logic                    out_ready;
	logic                    maybe_present;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	bit                      shadow_bits [STORE_BITS];
	logic [BIT_COUNT_W-1:0]  bit_count_q;
	logic [PROBE_COUNT_W-1:0] probe_count_q;
	bit                      answers_q [$];

	int unsigned mismatches;
	int unsigned answers_seen;
	int unsigned keys_sent;
	bit          sink_idle_en;
	bit          src_idle_en;
	bit          sink_hold;

	bloom_filter_double_hash dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .key_value(key_value),
		.out_valid(out_valid), .out_ready(out_ready), .maybe_present(maybe_present),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] mix64(input logic [63:0] v, input logic [63:0] seed);
		logic [63:0] x;
		x = (v ^ seed) + GOLDEN;
		x = (x ^ (x >> 30)) * MUL_A;
		x = (x ^ (x >> 27)) * MUL_B;
		return x ^ (x >> 31);
	endfunction

	function automatic bit apply_key(input logic is_query, input logic [63:0] key);
		logic [63:0] h1;
		logic [63:0] h2;
		logic [63:0] n;
		logic [63:0] k;
		logic [63:0] b;
		h1 = mix64(key, SEED_A);
		h2 = mix64(key, SEED_B);
		n = bit_count_q;
		if (n < 8) n = 8;
		if (n > STORE_BITS) n = STORE_BITS;
		k = probe_count_q;
		if (k < 1) k = 1;
		if (k > MAX_PROBES_DEF) k = MAX_PROBES_DEF;
		for (int unsigned i = 0; i < k; i++) begin
			b = (h1 + 64'(i) * h2) % n;
			if (is_query) begin
				if (!shadow_bits[b]) return 1'b0;
			end else begin
				shadow_bits[b] = 1'b1;
			end
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			answers_seen++;
			if (answers_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected answer %0b", maybe_present);
			end else begin
				bit exp_ans;
				exp_ans = answers_q.pop_front();
				if (maybe_present !== exp_ans) begin
					mismatches++;
					if (mismatches <= 10)
						$display("maybe_present mismatch: expected %0b got %0b",
							exp_ans, maybe_present);
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				sink_hold = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 11);
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_key(input logic is_query, input logic [63:0] key);
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= is_query;
		key_value <= key;
		do @(posedge clk); while (!in_ready);
		if (is_query) answers_q.push_back(apply_key(1'b1, key));
		else void'(apply_key(1'b0, key));
		keys_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (answers_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BIT_COUNT) bit_count_q = val;
		else if (idx == REG_PROBE_COUNT) probe_count_q = val[PROBE_COUNT_W-1:0];
	endtask

	function automatic logic [63:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		logic [63:0] edge_keys [4];
		edge_keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h1};
		foreach (edge_keys[i]) send_key(OP_QUERY, edge_keys[i]);
		foreach (edge_keys[i]) send_key(OP_ADD, edge_keys[i]);
		foreach (edge_keys[i]) send_key(OP_QUERY, edge_keys[i]);
		send_key(OP_QUERY, 64'h0123_4567_89AB_CDEF);
	endtask

	task automatic test_saturation();
		write_reg(REG_BIT_COUNT, 17'd3);
		write_reg(REG_PROBE_COUNT, 17'd0);
		send_key(OP_ADD, 64'hDEAD_BEEF);
		send_key(OP_QUERY, 64'hDEAD_BEEF);
		send_key(OP_QUERY, rand_key());
		write_reg(REG_BIT_COUNT, 17'h1FFFF);
		write_reg(REG_PROBE_COUNT, 17'h3F);
		send_key(OP_QUERY, 64'hDEAD_BEEF);
		send_key(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_key(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		// out-of-list index must be ignored
		write_reg(2'd3, 17'd9);
		write_reg(2'd2, 17'd9);
	endtask

	task automatic run_random(input int unsigned count);
		logic [63:0] added [$];
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				added.push_back(rand_key());
				send_key(OP_ADD, added[$]);
			end else if (added.size() != 0 && $urandom_range(0, 1) == 0) begin
				send_key(OP_QUERY, added[$urandom_range(0, added.size() - 1)]);
			end else begin
				send_key(OP_QUERY, rand_key());
			end
		end
	endtask

	task automatic test_random_configs();
		int unsigned bit_set [5];
		int unsigned probe_set [5];
		bit_set   = '{8, 65536, 64, 1000, 16384};
		probe_set = '{1, 32, 3, 12, 7};
		for (int unsigned c = 0; c < 5; c++) begin
			write_reg(REG_BIT_COUNT, CFG_DATA_W'(bit_set[c]));
			write_reg(REG_PROBE_COUNT, CFG_DATA_W'(probe_set[c]));
			run_random(80);
		end
	endtask

	task automatic test_backpressure();
		sink_hold = 1'b1;
		for (int unsigned i = 0; i < 8; i++) send_key(OP_QUERY, rand_key());
	endtask

	task automatic test_no_idle();
		drain();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		write_reg(REG_BIT_COUNT, CFG_DATA_W'($urandom_range(8, 65536)));
		write_reg(REG_PROBE_COUNT, CFG_DATA_W'($urandom_range(1, 32)));
		run_random(60);
	endtask

	initial begin
		mismatches = 0;
		answers_seen = 0;
		keys_sent = 0;
		sink_hold = 1'b0;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ADD;
		key_value = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BIT_COUNT;
		cfg_data = '0;
		bit_count_q = BIT_COUNT_RST;
		probe_count_q = PROBE_COUNT_RST;
		foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_saturation();
		test_backpressure();
		test_random_configs();
		test_no_idle();
		drain();
		$display("Sent %0d keys, checked %0d query answers across bit and probe count settings",
			keys_sent, answers_seen);
		$display("including saturated registers, ignored writes and a long output stall");
		if (mismatches == 0 && answers_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
